[rtl/stcs_pkg.sv]
`default_nettype none
package stcs_pkg;

    localparam logic [3:0] MODE_ADD     = 4'd0;
    localparam logic [3:0] MODE_DELETE  = 4'd1;
    localparam logic [3:0] MODE_SWAP    = 4'd2;
    localparam logic [3:0] MODE_UPDATE  = 4'd3;
    localparam logic [3:0] MODE_HIT     = 4'd4;
    localparam logic [3:0] MODE_IDCOUNT = 4'd5;
    localparam logic [3:0] MODE_IDFIRST = 4'd6;
    localparam logic [3:0] MODE_IDLAST  = 4'd7;
    localparam logic [3:0] MODE_READ    = 4'd8;
    localparam logic [3:0] MODE_CLEAR   = 4'd9;

    // one table entry as stored in memory
    localparam int ENTRY_W = 16 * 4 + 8 * 3 + 1;

    typedef struct packed {
        logic signed [15:0] id;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] base;
        logic [7:0]         width;
        logic [7:0]         height;
        logic [7:0]         zsize;
        logic               collidable;
    } t_entry;

    typedef struct packed {
        logic [3:0]         mode;
        logic [7:0]         index_a;
        logic [7:0]         index_b;
        logic signed [15:0] key_id;
        logic [15:0]        key_mask;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic signed [15:0] box_z;
        logic [7:0]         box_w;
        logic [7:0]         box_h;
        logic [7:0]         box_d;
        logic               collidable;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [7:0]         result_index;
        logic [8:0]         result_count;
        logic [8:0]         entries;
        logic signed [15:0] read_id;
        logic signed [15:0] read_x;
        logic signed [15:0] read_y;
    } t_out;

endpackage
`default_nettype wire

[rtl/stcs_ram.sv]
`default_nettype none
module stcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]                               i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]                               o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/sprite_table_collision_search_top.sv]
`default_nettype none
// Ordered object table with 3D box collision search. Each entry lives in one
// RAM word with a registered read; one beat is taken at a time and its result
// must be taken before the next beat is accepted. Searches walk the table one
// entry per cycle from the RAM read port (searches for a first or last match
// stop at the hit; an empty table is not walked); delete shifts the tail down
// one entry per cycle.
module sprite_table_collision_search_top
    import stcs_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_SWAPB = 3'd2;
    localparam logic [2:0] S_SWAPW = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_in           r_cmd, n_cmd;
    logic [CW-1:0] r_ptr, n_ptr;       // next address issued to RAM
    logic [CW-1:0] r_cur, n_cur;       // address whose data appears now (delete: address written now)
    logic [CW-1:0] r_tally, n_tally;
    logic          r_found, n_found;
    logic [CW-1:0] r_idx, n_idx;
    t_entry        r_hold, n_hold;
    t_out          r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [ENTRY_W-1:0] rdata_bits;

    stcs_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_bits)
    );
    assign rdata = t_entry'(rdata_bits);

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    // per-entry tests on the read data
    logic        id_hit, box_ok;
    logic [15:0] mkey;
    always_comb begin
        mkey   = r_cmd.key_id & r_cmd.key_mask;
        id_hit = ((rdata.id & r_cmd.key_mask) == mkey);
        box_ok = !rdata.id[15] && rdata.collidable
            && ($signed({r_cmd.box_x[15], r_cmd.box_x}) + $signed({9'd0, r_cmd.box_w})
                > $signed({rdata.left[15], rdata.left}))
            && ($signed({r_cmd.box_y[15], r_cmd.box_y}) + $signed({9'd0, r_cmd.box_h})
                > $signed({rdata.top[15], rdata.top}))
            && ($signed({r_cmd.box_z[15], r_cmd.box_z}) + $signed({9'd0, r_cmd.box_d})
                > $signed({rdata.base[15], rdata.base}))
            && ($signed({r_cmd.box_x[15], r_cmd.box_x})
                < $signed({rdata.left[15], rdata.left}) + $signed({9'd0, rdata.width}))
            && ($signed({r_cmd.box_y[15], r_cmd.box_y})
                < $signed({rdata.top[15], rdata.top}) + $signed({9'd0, rdata.height}))
            && ($signed({r_cmd.box_z[15], r_cmd.box_z})
                < $signed({rdata.base[15], rdata.base}) + $signed({9'd0, rdata.zsize}));
    end

    function automatic t_entry box_entry(input t_in c, input logic signed [15:0] id);
        t_entry e;
        e.id = id; e.left = c.box_x; e.top = c.box_y; e.base = c.box_z;
        e.width = c.box_w; e.height = c.box_h; e.zsize = c.box_d;
        e.collidable = c.collidable;
        return e;
    endfunction

    logic [IW-1:0] ia, ib;
    logic          walk_last;
    always_comb begin
        ia = IW'(r_cmd.index_a);
        ib = IW'(r_cmd.index_b);
        if (i_valid && o_ready) begin
            ia = IW'(i_data.index_a);
            ib = IW'(i_data.index_b);
        end
    end

    always_comb begin
        n_state = r_state; n_count = r_count; n_cmd = r_cmd; n_ptr = r_ptr;
        n_cur = r_cur; n_tally = r_tally; n_found = r_found;
        n_idx = r_idx; n_hold = r_hold; n_out = r_out;
        we = 1'b0; waddr = '0; wdata = rdata; raddr = r_ptr[AW-1:0];
        walk_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_out = '0;
                n_tally = '0; n_found = 1'b0; n_idx = '0;
                if (i_valid && o_ready) begin
                    n_cmd = i_data;
                    n_out.ok = 1'b1;
                    n_state = S_OUT;
                    case (i_data.mode)
                        MODE_ADD: begin
                            if (r_count < CW'(CAPACITY)) begin
                                we = 1'b1; waddr = r_count[AW-1:0];
                                wdata = box_entry(i_data, i_data.key_id);
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        MODE_DELETE: begin
                            if (ia < r_count) begin
                                n_ptr = CW'(ia) + 1'b1; n_cur = CW'(ia);
                                raddr = n_ptr[AW-1:0];
                                if (n_ptr < r_count) begin
                                    n_ptr = n_ptr + 1'b1;
                                    n_state = S_WALK;
                                end else begin
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        MODE_SWAP: begin
                            if (ia < r_count && ib < r_count) begin
                                raddr = ia[AW-1:0]; n_state = S_SWAPB;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        MODE_UPDATE: begin
                            if (ia < r_count) begin
                                raddr = ia[AW-1:0]; n_state = S_READ;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        MODE_READ: begin
                            if (ia < r_count) begin
                                raddr = ia[AW-1:0]; n_state = S_READ;
                            end else begin
                                n_out.ok = 1'b0;
                            end
                        end
                        MODE_HIT, MODE_IDCOUNT, MODE_IDFIRST: begin
                            if (r_count != '0) begin
                                raddr = '0; n_cur = '0;
                                n_ptr = CW'(1); n_state = S_WALK;
                            end
                        end
                        MODE_IDLAST: begin
                            if (r_count != '0) begin
                                n_cur = r_count - 1'b1; raddr = n_cur[AW-1:0];
                                n_ptr = n_cur; n_state = S_WALK;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                    n_out.entries = 9'(n_count);
                end
            end

            S_WALK: begin
                case (r_cmd.mode)
                    MODE_DELETE: begin
                        // shift entry cur+1 down into cur
                        we = 1'b1; waddr = r_cur[AW-1:0]; wdata = rdata;
                        raddr = r_ptr[AW-1:0];
                        n_cur = r_cur + 1'b1;
                        if (r_ptr < r_count) begin
                            n_ptr = r_ptr + 1'b1;
                        end else begin
                            walk_last = 1'b1;
                        end
                    end
                    MODE_IDLAST: begin
                        if (id_hit) begin
                            n_found = 1'b1; n_idx = r_cur; walk_last = 1'b1;
                        end else if (r_cur == '0) begin
                            walk_last = 1'b1;
                        end else begin
                            n_cur = r_cur - 1'b1; raddr = n_cur[AW-1:0];
                        end
                    end
                    default: begin
                        if (r_cmd.mode == MODE_IDCOUNT && id_hit) begin
                            n_tally = r_tally + 1'b1;
                        end
                        if ((r_cmd.mode == MODE_HIT && box_ok)
                            || (r_cmd.mode == MODE_IDFIRST && id_hit)) begin
                            n_found = 1'b1; n_idx = r_cur; walk_last = 1'b1;
                        end else if (r_cur + 1'b1 >= r_count) begin
                            walk_last = 1'b1;
                        end else begin
                            n_cur = r_cur + 1'b1; raddr = n_cur[AW-1:0];
                        end
                    end
                endcase
                if (walk_last) begin
                    if (r_cmd.mode == MODE_DELETE) begin
                        n_count = r_count - 1'b1;
                    end
                    n_out.found = n_found;
                    n_out.result_index = 8'(n_idx);
                    n_out.result_count = 9'(n_tally);
                    n_out.entries = 9'(n_count);
                    n_state = S_OUT;
                end
            end

            S_SWAPB: begin
                // hold entry a, fetch entry b
                n_hold = rdata; raddr = ib[AW-1:0]; n_state = S_SWAPW;
            end

            S_SWAPW: begin
                we = 1'b1; waddr = ia[AW-1:0]; wdata = rdata;
                n_state = S_READ;
            end

            S_READ: begin
                if (r_cmd.mode == MODE_SWAP) begin
                    we = 1'b1; waddr = ib[AW-1:0]; wdata = r_hold;
                end else if (r_cmd.mode == MODE_UPDATE) begin
                    we = 1'b1; waddr = ia[AW-1:0];
                    wdata = box_entry(r_cmd, rdata.id);
                end else begin
                    n_out.read_id = rdata.id;
                    n_out.read_x = rdata.left;
                    n_out.read_y = rdata.top;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_ptr <= n_ptr; r_cur <= n_cur; r_tally <= n_tally;
        r_found <= n_found; r_idx <= n_idx; r_hold <= n_hold; r_out <= n_out;
    end
endmodule
`default_nettype wire

[tb/sv/tb_sprite_table_collision_search_top.sv]
`default_nettype none
module tb_sprite_table_collision_search_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stcs_pkg::*;

    localparam int CAP = 256;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    sprite_table_collision_search_top #(.CAPACITY(CAP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // shadow copy of the object table
    t_entry tbl [CAP];
    int     tbl_count;

    t_out   pending_results [$];
    int     mismatches;
    int     beats_in;
    int     beats_out;
    int     idle_cycles = 0;
    bit     timed_out = 1'b0;
    int     hits_found;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit box_overlaps(t_entry e, t_in q);
        int x, y, z;
        x = q.box_x;
        y = q.box_y;
        z = q.box_z;
        if (e.id < 0 || !e.collidable) return 1'b0;
        return (x + int'(q.box_w) > int'(e.left)) && (y + int'(q.box_h) > int'(e.top))
            && (z + int'(q.box_d) > int'(e.base))
            && (x < int'(e.left) + int'(e.width)) && (y < int'(e.top) + int'(e.height))
            && (z < int'(e.base) + int'(e.zsize));
    endfunction

    function automatic bit id_matches(t_entry e, t_in q);
        return (e.id & q.key_mask) == (q.key_id & q.key_mask);
    endfunction

    function automatic t_entry entry_from(t_in q, logic signed [15:0] id);
        t_entry e;
        e.id = id;
        e.left = q.box_x;
        e.top = q.box_y;
        e.base = q.box_z;
        e.width = q.box_w;
        e.height = q.box_h;
        e.zsize = q.box_d;
        e.collidable = q.collidable;
        return e;
    endfunction

    // apply one operation to the shadow table and return its result
    function automatic t_out apply_table_op(t_in q);
        t_out r;
        t_entry tmp;
        r = '0;
        case (q.mode)
            MODE_ADD: if (tbl_count < CAP) begin
                tbl[tbl_count] = entry_from(q, q.key_id);
                tbl_count++;
                r.ok = 1'b1;
            end
            MODE_DELETE: if (q.index_a < tbl_count) begin
                for (int i = q.index_a; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
                tbl_count--;
                r.ok = 1'b1;
            end
            MODE_SWAP: if (q.index_a < tbl_count && q.index_b < tbl_count) begin
                tmp = tbl[q.index_a];
                tbl[q.index_a] = tbl[q.index_b];
                tbl[q.index_b] = tmp;
                r.ok = 1'b1;
            end
            MODE_UPDATE: if (q.index_a < tbl_count) begin
                tbl[q.index_a] = entry_from(q, tbl[q.index_a].id);
                r.ok = 1'b1;
            end
            MODE_HIT: begin
                r.ok = 1'b1;
                for (int i = 0; i < tbl_count; i++)
                    if (box_overlaps(tbl[i], q)) begin
                        r.found = 1'b1;
                        r.result_index = i[7:0];
                        break;
                    end
            end
            MODE_IDCOUNT: begin
                r.ok = 1'b1;
                for (int i = 0; i < tbl_count; i++)
                    if (id_matches(tbl[i], q)) r.result_count++;
            end
            MODE_IDFIRST: begin
                r.ok = 1'b1;
                for (int i = 0; i < tbl_count; i++)
                    if (id_matches(tbl[i], q)) begin
                        r.found = 1'b1;
                        r.result_index = i[7:0];
                        break;
                    end
            end
            MODE_IDLAST: begin
                r.ok = 1'b1;
                for (int i = tbl_count - 1; i >= 0; i--)
                    if (id_matches(tbl[i], q)) begin
                        r.found = 1'b1;
                        r.result_index = i[7:0];
                        break;
                    end
            end
            MODE_READ: if (q.index_a < tbl_count) begin
                r.ok = 1'b1;
                r.read_id = tbl[q.index_a].id;
                r.read_x = tbl[q.index_a].left;
                r.read_y = tbl[q.index_a].top;
            end
            MODE_CLEAR: begin
                tbl_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.entries = tbl_count[8:0];
        return r;
    endfunction

    // send one beat after a random gap and predict its result
    task automatic send_op(t_in q, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= q;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(apply_table_op(q));
        if (q.mode == MODE_HIT && pending_results[$].found) hits_found++;
        beats_in++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_in random_item();
        t_in q;
        q = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        q.mode = 4'($urandom_range(0, 15));
        return q;
    endfunction

    // keep indexes and coordinates near the table contents to get real hits
    function automatic t_in shaped_item();
        t_in q;
        int pick;
        q = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 30) q.mode = MODE_ADD;
        else if (pick < 38) q.mode = MODE_DELETE;
        else if (pick < 44) q.mode = MODE_SWAP;
        else if (pick < 50) q.mode = MODE_UPDATE;
        else if (pick < 68) q.mode = MODE_HIT;
        else if (pick < 74) q.mode = MODE_IDCOUNT;
        else if (pick < 80) q.mode = MODE_IDFIRST;
        else if (pick < 86) q.mode = MODE_IDLAST;
        else if (pick < 94) q.mode = MODE_READ;
        else if (pick < 95) q.mode = MODE_CLEAR;
        if ($urandom_range(0, 4) != 0) begin
            q.index_a = 8'($urandom_range(0, (tbl_count > 0) ? tbl_count : 0));
            q.index_b = 8'($urandom_range(0, (tbl_count > 0) ? tbl_count - 1 : 0));
            q.box_x = 16'(int'($urandom_range(0, 400)) - 200);
            q.box_y = 16'(int'($urandom_range(0, 400)) - 200);
            q.box_z = 16'(int'($urandom_range(0, 400)) - 200);
            q.key_mask = ($urandom_range(0, 1)) ? 16'h000F : q.key_mask;
        end
        return q;
    endfunction

    task automatic test_directed_extremes();
        t_in q;
        q = '0;
        q.mode = MODE_HIT;
        send_op(q);                               // search on empty table
        q.mode = MODE_READ;
        send_op(q);                               // bad index read
        q.mode = MODE_ADD;
        q.key_id = 16'sh7FFF; q.box_x = 16'sh7FFF; q.box_y = 16'sh7FFF; q.box_z = 16'sh7FFF;
        q.box_w = 8'hFF; q.box_h = 8'hFF; q.box_d = 8'hFF; q.collidable = 1'b1;
        send_op(q);
        q.key_id = -16'sd32768; q.box_x = -16'sd32768; q.box_y = -16'sd32768;
        q.box_z = -16'sd32768;
        send_op(q);                               // negative id never collides
        q.key_id = 16'sd5; q.box_x = 16'sd0; q.box_y = 16'sd0; q.box_z = 16'sd0;
        q.box_w = 8'd10; q.box_h = 8'd10; q.box_d = 8'd10;
        send_op(q);
        q.mode = MODE_HIT;
        send_op(q);
        q.box_x = 16'sd10;                        // touching edge: no overlap
        send_op(q);
        q.box_x = 16'sh7FFF; q.box_y = 16'sh7FFF; q.box_z = 16'sh7FFF;
        send_op(q);                               // top corner, no wrap
        q.mode = MODE_SWAP; q.index_a = 8'd0; q.index_b = 8'd2;
        send_op(q);
        q.mode = MODE_UPDATE; q.index_a = 8'd1; q.collidable = 1'b0;
        send_op(q);
        q.mode = MODE_IDCOUNT; q.key_mask = 16'h0000;
        send_op(q);
        q.mode = MODE_IDFIRST; q.key_mask = 16'hFFFF; q.key_id = 16'sh7FFF;
        send_op(q);
        q.mode = MODE_IDLAST; q.key_mask = 16'h8000; q.key_id = -16'sd1;
        send_op(q);
        q.mode = MODE_READ; q.index_a = 8'd2;
        send_op(q);
        q.mode = MODE_DELETE; q.index_a = 8'd0;
        send_op(q);
        q.mode = 4'd15;                           // unused mode
        send_op(q);
        q.mode = MODE_SWAP; q.index_a = 8'hFF; q.index_b = 8'd0;
        send_op(q);
        q.mode = MODE_CLEAR;
        send_op(q);
    endtask

    // fill past capacity, check full-table refusal, delete from the head
    task automatic test_full_table();
        t_in q;
        for (int i = 0; i <= CAP; i++) begin
            q = random_item();
            q.mode = MODE_ADD;
            send_op(q, 1'b1);
        end
        q.mode = MODE_IDLAST; q.key_mask = 16'h0000;
        send_op(q);
        q.mode = MODE_DELETE; q.index_a = 8'd0;
        send_op(q);
        q.mode = MODE_READ; q.index_a = 8'hFE;
        send_op(q);
        drain_results();                          // sender waits for all results
        q.mode = MODE_CLEAR;
        send_op(q);
    endtask

    task automatic test_random_ops();
        for (int n = 0; n < 900; n++) begin
            send_op(shaped_item());
            if (tbl_count > 60 && $urandom_range(0, 9) == 0) begin
                t_in q;
                q = random_item();
                q.mode = MODE_CLEAR;
                send_op(q);
            end
        end
    endtask

    // receiver with random stalls
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", o_data);
            end else begin
                t_out want;
                want = pending_results.pop_front();
                if (o_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p got %p",
                                 beats_out, want, o_data);
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        tbl_count = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        hits_found = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            begin
                test_directed_extremes();
                test_full_table();
                test_random_ops();
                drain_results();
            end
            wait (timed_out);
        join_any
        if (timed_out) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("tb_sprite_table_collision_search_top NOT OK");
        end else begin
            $display("sent %0d operations, checked %0d results, %0d box hits found",
                     beats_in, beats_out, hits_found);
            if (mismatches == 0) $display("tb_sprite_table_collision_search_top OK");
            else $display("tb_sprite_table_collision_search_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/stcs_pkg.sv
rtl/stcs_ram.sv
rtl/sprite_table_collision_search_top.sv
tb/sv/tb_sprite_table_collision_search_top.sv
